@@ hdl/linear_interp_audio_resampler_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the linear interpolation resampler
// Shared shorthands for the concurrent checks in the resampler modules.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_AUDIO_RESAMPLER_CORE_ASSERT_SVH
`define LINEAR_INTERP_AUDIO_RESAMPLER_CORE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define LIRS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that holds in the same cycle whenever the trigger holds.
`define LIRS_ASSERT_IMPLIES(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

@@ hdl/lirs_pkg.sv @@
// ----------------------------------------------------------------------------
// Resampler package
// Widths, constants, register indexes and shared types of the resampler.
// ----------------------------------------------------------------------------
package lirs_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int SAMPLE_W      = 16;
    localparam int STEP_W        = 24;
    localparam int PHASE_W       = 25;
    localparam int CHAN_W        = 2;
    localparam int CFG_DATA_W    = STEP_W;
    localparam int CFG_INDEX_W   = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    // One whole input frame of phase, and two of them.
    localparam logic [PHASE_W-1:0] ONE_UNIT  = PHASE_W'(1) << FRACTION_BITS;
    localparam logic [PHASE_W-1:0] TWO_UNITS = PHASE_W'(1) << (FRACTION_BITS + 1);

    // Smallest step accepted; smaller writes are raised to it.
    localparam logic [STEP_W-1:0] MIN_STEP   = STEP_W'(1) << (FRACTION_BITS - 5);
    localparam logic [STEP_W-1:0] RESET_STEP = STEP_W'(1) << FRACTION_BITS;

    localparam logic [CHAN_W-1:0] CHAN_MONO   = 2'd1;
    localparam logic [CHAN_W-1:0] CHAN_STEREO = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP      = 2'd0,
        CFG_SOURCE_CHANNELS = 2'd1,
        CFG_TARGET_CHANNELS = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       last;
    } frame_t;

    typedef struct packed {
        logic  valid;
        frame_t frame;
    } queue_head_t;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic              target_mono;
        logic              clear;
    } back_cfg_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_RUN_HELD,
        BACK_RUN_FLUSH
    } back_state_t;

endpackage

@@ hdl/lirs_front.sv @@
// ----------------------------------------------------------------------------
// Resampler front end
// Accepts input frames, resolves the source channel mode and queues them.
// ----------------------------------------------------------------------------
`include "linear_interp_audio_resampler_core_assert.svh"

module lirs_front
    import lirs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [2*SAMPLE_W-1:0] s_tdata,   // left_sample, right_sample
    input  logic                  s_tlast,   // last_in_block
    input  logic                  source_mono,
    input  logic                  pop,
    output queue_head_t           head
);

    frame_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                push;
    frame_t              in_frame;

    // A mono source carries its left sample on both channels.
    always_comb
    begin
        in_frame.left  = s_tdata[SAMPLE_W-1:0];
        in_frame.right = source_mono ? s_tdata[SAMPLE_W-1:0] : s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        in_frame.last  = s_tlast;
    end

    assign s_tready = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_frame;
        end
    end

    always_comb
    begin
        head.valid = (count_reg != '0);
        head.frame = mem_reg[rd_ptr_reg];
    end

    `LIRS_ASSERT_ALWAYS(a_queue_bounded, count_reg <= QUEUE_CW'(QUEUE_DEPTH), "queue over depth")
    `LIRS_ASSERT_IMPLIES(a_pop_not_empty, pop, count_reg != '0, "pop from empty queue")

endmodule

@@ hdl/lirs_back.sv @@
// ----------------------------------------------------------------------------
// Resampler back end
// Walks the phase accumulator over each interval and emits interpolated items.
// ----------------------------------------------------------------------------
`include "linear_interp_audio_resampler_core_assert.svh"

module lirs_back
    import lirs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  back_cfg_t             cfg,
    input  queue_head_t           head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2*SAMPLE_W-1:0] m_tdata,   // out_left, out_right
    output logic                  m_tlast,   // last_of_run
    output logic                  m_tuser    // block_finished
);

    back_state_t                state_reg;
    back_state_t                state_next;
    logic [PHASE_W-1:0]         phase_reg;
    logic [PHASE_W-1:0]         phase_next;
    logic signed [SAMPLE_W-1:0] held_left_reg;
    logic signed [SAMPLE_W-1:0] held_left_next;
    logic signed [SAMPLE_W-1:0] held_right_reg;
    logic signed [SAMPLE_W-1:0] held_right_next;
    logic                       have_held_reg;
    logic                       have_held_next;
    frame_t                     cur_reg;
    frame_t                     cur_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [SAMPLE_W-1:0]        out_left_reg;
    logic [SAMPLE_W-1:0]        out_left_next;
    logic [SAMPLE_W-1:0]        out_right_reg;
    logic [SAMPLE_W-1:0]        out_right_next;
    logic                       out_last_reg;
    logic                       out_last_next;
    logic                       out_finished_reg;
    logic                       out_finished_next;

    logic                       slot_free;
    logic                       in_interval;
    logic                       emit;
    logic [PHASE_W-1:0]         phase_stepped;
    logic                       run_final;
    logic signed [SAMPLE_W-1:0] from_left;
    logic signed [SAMPLE_W-1:0] from_right;
    logic signed [SAMPLE_W-1:0] lerp_left;
    logic signed [SAMPLE_W-1:0] lerp_right;

    // a + floor((b - a) * frac / one); the result always lies between a and b.
    function automatic logic signed [SAMPLE_W-1:0] lerp_sample(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic [FRACTION_BITS-1:0]   frac
    );
        logic signed [SAMPLE_W:0]                 diff;
        logic signed [SAMPLE_W+FRACTION_BITS+1:0] prod;
        logic signed [SAMPLE_W+FRACTION_BITS+1:0] part;
        diff = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
        prod = diff * $signed({1'b0, frac});
        part = prod >>> FRACTION_BITS;
        return a + part[SAMPLE_W-1:0];
    endfunction

    // (l + r) / 2 rounded toward zero.
    function automatic logic [SAMPLE_W-1:0] mix_mono(
        input logic signed [SAMPLE_W-1:0] l,
        input logic signed [SAMPLE_W-1:0] r
    );
        logic signed [SAMPLE_W:0] sum;
        logic signed [SAMPLE_W:0] adj;
        sum = {l[SAMPLE_W-1], l} + {r[SAMPLE_W-1], r};
        adj = sum + {{SAMPLE_W{1'b0}}, sum[SAMPLE_W]};
        return adj[SAMPLE_W:1];
    endfunction

    assign slot_free     = !out_valid_reg || m_tready;
    assign in_interval   = (phase_reg < ONE_UNIT);
    assign phase_stepped = phase_reg + PHASE_W'(cfg.phase_step);

    // In the flush interval both ends are the current frame.
    assign from_left  = (state_reg == BACK_RUN_FLUSH) ? cur_reg.left  : held_left_reg;
    assign from_right = (state_reg == BACK_RUN_FLUSH) ? cur_reg.right : held_right_reg;
    assign lerp_left  = lerp_sample(from_left,  cur_reg.left,  phase_reg[FRACTION_BITS-1:0]);
    assign lerp_right = lerp_sample(from_right, cur_reg.right, phase_reg[FRACTION_BITS-1:0]);

    // The item is the last of its frame when the next position leaves the
    // interval, and for a last frame also skips the whole flush interval.
    always_comb
    begin
        case (state_reg)
            BACK_RUN_HELD:
            begin
                run_final = cur_reg.last ? (phase_stepped >= TWO_UNITS)
                                         : (phase_stepped >= ONE_UNIT);
            end
            BACK_RUN_FLUSH:
            begin
                run_final = (phase_stepped >= ONE_UNIT);
            end
            default:
            begin
                run_final = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BACK_IDLE:
            begin
                if (head.valid)
                begin
                    if (have_held_reg)
                    begin
                        state_next = BACK_RUN_HELD;
                    end
                    else if (head.frame.last)
                    begin
                        state_next = BACK_RUN_FLUSH;
                    end
                end
            end
            BACK_RUN_HELD:
            begin
                if (!in_interval)
                begin
                    state_next = cur_reg.last ? BACK_RUN_FLUSH : BACK_IDLE;
                end
            end
            BACK_RUN_FLUSH:
            begin
                if (!in_interval)
                begin
                    state_next = BACK_IDLE;
                end
            end
            default:
            begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        pop  = 1'b0;
        emit = 1'b0;
        case (state_reg)
            BACK_IDLE:
            begin
                pop = head.valid;
            end
            BACK_RUN_HELD, BACK_RUN_FLUSH:
            begin
                emit = in_interval && slot_free;
            end
            default:
            begin
                pop  = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    // Phase and held frame.
    always_comb
    begin
        phase_next      = phase_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        have_held_next  = have_held_reg;
        cur_next        = cur_reg;
        if (pop)
        begin
            cur_next = head.frame;
            if (!have_held_reg)
            begin
                held_left_next  = head.frame.left;
                held_right_next = head.frame.right;
                have_held_next  = 1'b1;
            end
        end
        if (emit)
        begin
            phase_next = phase_stepped;
        end
        else if (state_reg != BACK_IDLE && !in_interval)
        begin
            phase_next = phase_reg - ONE_UNIT;
            if (state_reg == BACK_RUN_HELD)
            begin
                held_left_next  = cur_reg.left;
                held_right_next = cur_reg.right;
                have_held_next  = 1'b1;
            end
            else
            begin
                held_left_next  = '0;
                held_right_next = '0;
                have_held_next  = 1'b0;
            end
        end
        if (cfg.clear)
        begin
            phase_next      = '0;
            held_left_next  = '0;
            held_right_next = '0;
            have_held_next  = 1'b0;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_left_next     = out_left_reg;
        out_right_next    = out_right_reg;
        out_last_next     = out_last_reg;
        out_finished_next = out_finished_reg;
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_last_next     = run_final;
            out_finished_next = run_final && cur_reg.last;
            if (cfg.target_mono)
            begin
                out_left_next  = mix_mono(lerp_left, lerp_right);
                out_right_next = '0;
            end
            else
            begin
                out_left_next  = lerp_left;
                out_right_next = lerp_right;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BACK_IDLE;
            phase_reg      <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
            have_held_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
            have_held_reg  <= have_held_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg          <= cur_next;
        out_left_reg     <= out_left_next;
        out_right_reg    <= out_right_next;
        out_last_reg     <= out_last_next;
        out_finished_reg <= out_finished_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_finished_reg;

    // The phase only grows by one step from inside an interval.
    `LIRS_ASSERT_ALWAYS(a_phase_bounded, phase_reg < ONE_UNIT + PHASE_W'(cfg.phase_step),
                        "phase out of range")
    `LIRS_ASSERT_IMPLIES(a_held_run_has_frame, state_reg == BACK_RUN_HELD, have_held_reg,
                         "interpolating without a held frame")
    `LIRS_ASSERT_IMPLIES(a_finish_is_last, out_valid_reg && out_finished_reg, out_last_reg,
                         "block finished on an item that is not last of its run")

endmodule

@@ hdl/linear_interp_audio_resampler_core.sv @@
// ----------------------------------------------------------------------------
// Linear interpolation audio resampler
// Each input frame arriving on the slave stream closes the interval that
// starts at the previously held frame, and every output position that a Q16
// phase accumulator places inside that interval is produced by linear
// interpolation between the two frames, one item per cycle on the unstalled
// master stream. A frame marked with tlast also flushes its own interval
// with the frame held flat, ends the block and clears the held frame, while
// the phase carries on. With one target channel the two channels are mixed
// as (l+r)/2, rounded toward zero. Input items land in a two-deep queue, so
// the stream can deliver the next frame while the back end is still working
// on the current one. For each frame the back end takes the frame from the
// queue, produces its results one after another and then closes each interval
// that the frame ends, the flush interval included. With the smallest
// step of 2048 a frame gives at most 64 results. A stalled master stream holds
// the back end, since results leave through a single output register. Any
// configuration write to a known register clears the phase and the held frame;
// configuration is to be written only while the block is idle.
// ----------------------------------------------------------------------------
module linear_interp_audio_resampler_core
    import lirs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*SAMPLE_W-1:0]  s_tdata,   // left_sample, right_sample
    input  logic                   s_tlast,   // last_in_block
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [2*SAMPLE_W-1:0]  m_tdata,   // out_left, out_right
    output logic                   m_tlast,   // last_of_run
    output logic                   m_tuser    // block_finished
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [CHAN_W-1:0] src_chan_reg;
    logic [CHAN_W-1:0] src_chan_next;
    logic [CHAN_W-1:0] tgt_chan_reg;
    logic [CHAN_W-1:0] tgt_chan_next;
    logic              cfg_hit;
    back_cfg_t         back_cfg;
    queue_head_t       head;
    logic              pop;

    // Register file. Writes to an unknown index are ignored entirely, and
    // steps below the minimum are raised to it so a frame never produces
    // more than 64 results.
    always_comb
    begin
        step_next     = step_reg;
        src_chan_next = src_chan_reg;
        tgt_chan_next = tgt_chan_reg;
        cfg_hit       = cfg_write_en && (cfg_index inside {CFG_PHASE_STEP,
                                                           CFG_SOURCE_CHANNELS,
                                                           CFG_TARGET_CHANNELS});
        if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PHASE_STEP:
                begin
                    step_next = (cfg_data < MIN_STEP) ? MIN_STEP : cfg_data;
                end
                CFG_SOURCE_CHANNELS:
                begin
                    src_chan_next = cfg_data[CHAN_W-1:0];
                end
                CFG_TARGET_CHANNELS:
                begin
                    tgt_chan_next = cfg_data[CHAN_W-1:0];
                end
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= RESET_STEP;
            src_chan_reg <= CHAN_STEREO;
            tgt_chan_reg <= CHAN_STEREO;
        end
        else
        begin
            step_reg     <= step_next;
            src_chan_reg <= src_chan_next;
            tgt_chan_reg <= tgt_chan_next;
        end
    end

    // Any channel code other than one is treated as stereo.
    always_comb
    begin
        back_cfg.phase_step  = step_reg;
        back_cfg.target_mono = (tgt_chan_reg == CHAN_MONO);
        back_cfg.clear       = cfg_hit;
    end

    lirs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .source_mono (src_chan_reg == CHAN_MONO),
        .pop         (pop),
        .head        (head)
    );

    lirs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (back_cfg),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the linear interpolation audio resampler
// Frames are streamed into the slave port while results are collected on the
// master port. Every accepted frame is run through a behavioural model of the
// phase accumulator and interpolator kept in this module. Every result that
// leaves the block is compared field by field against the oldest prediction.
// Both stream sides idle at random, and the receiver stalls once for a long
// stretch. Configuration is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
    import lirs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run limits. The cycle limit allows every frame its full 64 results,
    // several times over.
    localparam int          CYCLE_LIMIT    = 3_000_000;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_FRAMES   = 40;
    localparam int          MAX_BURST      = 64;
    localparam int          MAX_REPORTS    = 40;
    localparam longint      FRAC_MASK      = (longint'(1) << FRACTION_BITS) - 1;
    localparam longint      PHASE_MASK     = (longint'(1) << PHASE_W) - 1;
    // A register index with no register behind it; the block ignores it.
    localparam logic [CFG_INDEX_W-1:0] UNUSED_INDEX = 2'd3;

    // One output item as the block should present it.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       run_end;
        logic                       block_end;
    } audio_out_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero.
    // ------------------------------------------------------------------------
    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   s_tvalid     = 1'b0;
    logic                   s_tready;
    logic [2*SAMPLE_W-1:0]  s_tdata      = '0;
    logic                   s_tlast      = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready     = 1'b0;
    logic [2*SAMPLE_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    always #2 clk = ~clk;

    linear_interp_audio_resampler_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Shared bookkeeping between the stimulus, the driver and the monitor.
    // ------------------------------------------------------------------------
    frame_t     frames_to_send[$];
    audio_out_t expected_samples[$];
    audio_out_t sweep_buf[$];
    int         frames_queued   = 0;
    int         frames_accepted = 0;
    int         error_count     = 0;
    int         cycle_count     = 0;
    bit         idle_en         = 1'b1;
    int         hold_requests   = 0;

    // ------------------------------------------------------------------------
    // Behavioural copy of the resampler state and its configuration. These
    // start at the reset values of the block.
    // ------------------------------------------------------------------------
    logic [STEP_W-1:0] step_reg   = RESET_STEP;
    logic [CHAN_W-1:0] src_chans  = CHAN_STEREO;
    logic [CHAN_W-1:0] tgt_chans  = CHAN_STEREO;
    int                held_left  = 0;
    int                held_right = 0;
    longint            phase_acc  = 0;
    bit                have_held  = 1'b0;

    // Linear interpolation from a toward b by frac, the correction term
    // rounded down toward minus infinity.
    function automatic int interp(input int a, input int b, input longint frac);
        longint prod;
        longint part;
        prod = longint'(b - a) * frac;
        if (prod >= 0)
        begin
            part = prod >>> FRACTION_BITS;
        end
        else
        begin
            part = -((-prod + FRAC_MASK) >>> FRACTION_BITS);
        end
        return a + int'(part);
    endfunction

    // Produces every output position that the phase places inside the current
    // interval, from frame a toward frame b, into sweep_buf. The phase then
    // loses one whole frame.
    task automatic sweep_interval(input int al, input int ar, input int bl, input int br);
        longint     ph;
        longint     frac;
        int         l;
        int         r;
        audio_out_t o;
        ph = phase_acc;
        while (ph < longint'(ONE_UNIT) && sweep_buf.size() < MAX_BURST)
        begin
            frac = ph & FRAC_MASK;
            l    = interp(al, bl, frac);
            r    = interp(ar, br, frac);
            o    = '0;
            if (tgt_chans == CHAN_MONO)
            begin
                // Mixdown divides with truncation toward zero.
                o.left  = SAMPLE_W'((l + r) / 2);
                o.right = '0;
            end
            else
            begin
                o.left  = SAMPLE_W'(l);
                o.right = SAMPLE_W'(r);
            end
            sweep_buf.push_back(o);
            ph = ph + longint'(step_reg);
        end
        if (ph >= longint'(ONE_UNIT))
        begin
            ph = ph - longint'(ONE_UNIT);
        end
        phase_acc = ph & PHASE_MASK;
    endtask

    // Works out every result that one accepted frame causes and queues them.
    task automatic interpolate_frame(input logic [SAMPLE_W-1:0] left_in,
                                     input logic [SAMPLE_W-1:0] right_in,
                                     input logic                last_in);
        int         nl;
        int         nr;
        audio_out_t tail;
        sweep_buf.delete();
        nl = int'($signed(left_in));
        // A mono source copies the left sample into both channels.
        nr = (src_chans == CHAN_MONO) ? nl : int'($signed(right_in));
        if (have_held)
        begin
            sweep_interval(held_left, held_right, nl, nr);
        end
        held_left  = nl;
        held_right = nr;
        have_held  = 1'b1;
        if (last_in)
        begin
            // The last frame of a block also flushes its own interval flat,
            // and the block then starts again with nothing held.
            sweep_interval(nl, nr, nl, nr);
            held_left  = 0;
            held_right = 0;
            have_held  = 1'b0;
        end
        if (sweep_buf.size() > 0)
        begin
            tail           = sweep_buf.pop_back();
            tail.run_end   = 1'b1;
            tail.block_end = last_in;
            sweep_buf.push_back(tail);
        end
        foreach (sweep_buf[i])
        begin
            expected_samples.push_back(sweep_buf[i]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stream driver. At each free slot it either opens an idle burst or puts
    // the next pending frame on the bus; a frame stays put until accepted.
    // ------------------------------------------------------------------------
    int src_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin : frame_driver
        frame_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                interpolate_frame(s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W],
                                  s_tlast);
                frames_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (idle_en && frames_to_send.size() != 0 &&
                         $urandom_range(0, 7) == 0)
                begin
                    src_gap  = int'($urandom_range(1, 18)) - 1;
                    s_tvalid <= 1'b0;
                end
                else if (frames_to_send.size() != 0)
                begin
                    nxt      = frames_to_send.pop_front();
                    s_tdata  <= {nxt.right, nxt.left};
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. It checks each accepted result against the oldest
    // prediction and decides the ready for the next cycle. A long hold-off,
    // once requested, is counted down here while the sender keeps offering.
    // ------------------------------------------------------------------------
    int sink_gap    = 0;
    int hold_left   = 0;
    int hold_served = 0;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        audio_out_t seen;
        audio_out_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.left      = m_tdata[SAMPLE_W-1:0];
                seen.right     = m_tdata[2*SAMPLE_W-1:SAMPLE_W];
                seen.run_end   = m_tlast;
                seen.block_end = m_tuser;
                if (expected_samples.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected result, expected none, actual l=%0d r=%0d last=%0b fin=%0b",
                                 $time, seen.left, seen.right, seen.run_end, seen.block_end);
                    end
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (seen.left !== want.left || seen.right !== want.right ||
                        seen.run_end !== want.run_end || seen.block_end !== want.block_end)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $display("%0t: mismatch, expected l=%0d r=%0d last=%0b fin=%0b, actual l=%0d r=%0d last=%0b fin=%0b",
                                     $time, want.left, want.right, want.run_end, want.block_end,
                                     seen.left, seen.right, seen.run_end, seen.block_end);
                        end
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 9) == 0)
            begin
                sink_gap = int'($urandom_range(1, 18)) - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic send_frame(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                              input logic last);
        frame_t f;
        f.left  = l;
        f.right = r;
        f.last  = last;
        frames_to_send.push_back(f);
        frames_queued++;
    endtask

    // Waits until every queued frame has been taken and every prediction has
    // been met, then gives the back end time to finish frames that yield
    // nothing, so that a register write finds the block idle.
    task automatic wait_until_drained();
        while (frames_accepted != frames_queued || expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register and applies the same change to the model. A write
    // to a known register clears the phase and the held frame.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        bit clears;
        clears = 1'b1;
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        case (idx)
            CFG_PHASE_STEP:
            begin
                step_reg = data;
                if (step_reg < MIN_STEP)
                begin
                    step_reg = MIN_STEP;
                end
            end
            CFG_SOURCE_CHANNELS: src_chans = data[CHAN_W-1:0];
            CFG_TARGET_CHANNELS: tgt_chans = data[CHAN_W-1:0];
            default:             clears = 1'b0;
        endcase
        if (clears)
        begin
            held_left  = 0;
            held_right = 0;
            phase_acc  = 0;
            have_held  = 1'b0;
        end
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Channel code with noise in the upper data bits; mostly the two real
    // codes, sometimes the unused ones that the block treats as stereo.
    function automatic logic [CFG_DATA_W-1:0] chan_word();
        logic [CHAN_W-1:0] code;
        case ($urandom_range(0, 5))
            0:       code = 2'd0;
            1:       code = 2'd3;
            2, 3:    code = CHAN_MONO;
            default: code = CHAN_STEREO;
        endcase
        return {(CFG_DATA_W - CHAN_W)'($urandom), code};
    endfunction

    // Step for a random phase: mostly near unity, sometimes clamped, very
    // fine or so coarse that most frames yield nothing.
    function automatic logic [CFG_DATA_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return CFG_DATA_W'($urandom_range(0, 2047));
            1:       return CFG_DATA_W'($urandom_range(2048, 8192));
            2:       return CFG_DATA_W'($urandom_range(200000, 16777215));
            default: return CFG_DATA_W'($urandom_range(20000, 150000));
        endcase
    endfunction

    // Sample that sits on a full-scale extreme now and then.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int ph;
        int k;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, unity step in stereo. The first frame is only held;
        // the third ends the block, and the fourth is first and last at once.
        send_frame(16'h7fff, 16'h8000, 1'b0);
        send_frame(16'h8000, 16'h7fff, 1'b0);
        send_frame(16'h0000, 16'h0000, 1'b1);
        send_frame(16'h1234, 16'hedcb, 1'b1);
        wait_until_drained();

        // A zero step is raised to the smallest one, giving full runs of
        // results across swings between the extremes, mixed to mono.
        write_reg(CFG_PHASE_STEP, 24'd0);
        write_reg(CFG_TARGET_CHANNELS, {22'h3fffff, CHAN_MONO});
        send_frame(16'h8000, 16'h7fff, 1'b0);
        send_frame(16'h7fff, 16'h8000, 1'b0);
        send_frame(16'hffff, 16'h0001, 1'b1);
        wait_until_drained();

        // Just below the smallest step, from a mono source to stereo.
        write_reg(CFG_PHASE_STEP, 24'd2047);
        write_reg(CFG_SOURCE_CHANNELS, {22'h000000, CHAN_MONO});
        write_reg(CFG_TARGET_CHANNELS, {22'h000000, CHAN_STEREO});
        send_frame(16'h1111, 16'haaaa, 1'b0);
        send_frame(16'h8001, 16'h5555, 1'b1);
        wait_until_drained();

        // The largest step pushes the phase far past each interval, so later
        // frames yield nothing, including a last frame on its own.
        write_reg(CFG_PHASE_STEP, 24'd1);
        write_reg(CFG_PHASE_STEP, 24'hffffff);
        write_reg(CFG_SOURCE_CHANNELS, {22'h2aaaaa, CHAN_STEREO});
        send_frame(16'h0100, 16'h0200, 1'b0);
        send_frame(16'h0300, 16'h0400, 1'b0);
        send_frame(16'h0500, 16'h0600, 1'b1);
        send_frame(16'h0700, 16'h0800, 1'b1);
        wait_until_drained();

        // Unused channel codes count as stereo. A write to the unused index
        // between two frames must leave the held frame and the phase alone.
        write_reg(CFG_SOURCE_CHANNELS, {22'h155555, 2'd0});
        write_reg(CFG_TARGET_CHANNELS, {22'h3fffff, 2'd3});
        write_reg(CFG_PHASE_STEP, 24'd98304);
        send_frame(16'h000a, 16'h0014, 1'b0);
        wait_until_drained();
        write_reg(UNUSED_INDEX, 24'h5a5a5a);
        send_frame(16'h001e, 16'h0028, 1'b0);
        send_frame(16'hffce, 16'h8000, 1'b1);
        wait_until_drained();

        // Random phases, each with fresh settings and blocks of random
        // length. The last two run without idling on either side.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idle_en = (ph < RANDOM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            write_reg(CFG_SOURCE_CHANNELS, chan_word());
            write_reg(CFG_TARGET_CHANNELS, chan_word());
            write_reg(CFG_PHASE_STEP, pick_step());
            for (k = 0; k < PHASE_FRAMES; k++)
            begin
                send_frame(pick_sample(), pick_sample(), ($urandom_range(0, 9) == 0));
            end
            // Once, the receiver stalls for long enough that the input queue
            // fills and the slave side has to push back.
            if (ph == 1)
            begin
                hold_requests++;
            end
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_samples.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ linear_interp_audio_resampler_core.f @@
+incdir+hdl
hdl/lirs_pkg.sv
hdl/lirs_front.sv
hdl/lirs_back.sv
hdl/linear_interp_audio_resampler_core.sv
tb/tb.sv
